>>> rtl/cscan_pkg.sv
// shared constants and types of the c-scan disk scheduler
package cscan_pkg;

	localparam int MAX_REQ = 32;
	localparam int ADDR_W = (MAX_REQ > 1) ? $clog2(MAX_REQ) : 1;
	localparam int CNT_W = $clog2(MAX_REQ + 1);
	localparam int CYL_W = 16;
	localparam int CC_W = 17;
	localparam int MOV_W = 18;
	localparam int CFG_IDX_W = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HEAD_START = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CYL_COUNT = 1'b1;

	// one access to the request store: write port and read address
	typedef struct packed {
		logic             we;
		logic [ADDR_W-1:0] waddr;
		logic [CYL_W-1:0]  wdata;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

endpackage

>>> rtl/cscan_ram.sv
// request store: one write port, one registered read port
module cscan_ram (
	input  logic                         clk,
	input  cscan_pkg::ram_req_t          req,
	output logic [cscan_pkg::CYL_W-1:0]  rdata
);

	logic [cscan_pkg::CYL_W-1:0] mem [cscan_pkg::MAX_REQ];
	logic [cscan_pkg::CYL_W-1:0] rdata_q;

	// write, and registered read
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata_q <= mem[req.raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/cscan_disk_scheduler_top.sv
// c-scan disk scheduler: batch load, in-place insertion sort, sweep emission
//
// channel   direction  handshake             word
// request   in         start & !busy         request_cylinder, last_request
// visit     out        strobe (one cycle)    visit_cylinder, total_movement, is_request,
//                                            overflow, last_visit
// config    in         cfg_valid & cfg_ready cfg_index, cfg_data
//
// a request that is not the last is written to the store while it has room, else
// it is dropped and marks the overflow output of its sweep. the last request starts
// a sort that reads and writes the single store and saturates each entry to the top
// cylinder. emission then reads the store once per pass and gives the start point
// before the first pass and the top and zero points after it;
// busy stays high until the final result is registered and config words are
// taken only while idle. reset clears the control state and sets head_start
// to 0 and cylinder_count to 200. results cannot be stalled.
module cscan_disk_scheduler_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [cscan_pkg::CYL_W-1:0]         request_cylinder,
	input  logic                                last_request,
	output logic                                strobe,
	output logic [cscan_pkg::CYL_W-1:0]         visit_cylinder,
	output logic [cscan_pkg::MOV_W-1:0]         total_movement,
	output logic                                is_request,
	output logic                                overflow,
	output logic                                last_visit,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cscan_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cscan_pkg::CC_W-1:0]          cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_KRD, S_KEY, S_CMP, S_PUT, S_START,
		S_ARD, S_AEV, S_TOP, S_ZERO, S_BRD, S_BEV
	} state_t;

	localparam int AW = cscan_pkg::ADDR_W;
	localparam int CW = cscan_pkg::CNT_W;
	localparam int YW = cscan_pkg::CYL_W;
	localparam int MW = cscan_pkg::MOV_W;

	state_t           state_q;
	logic [CW-1:0]    count_q;
	logic             dropped_q;
	logic [CW-1:0]    i_q;
	logic [AW-1:0]    j_q;
	logic [CW-1:0]    cnt_b_q;
	logic [YW-1:0]    key_q;
	logic [YW-1:0]    pos_q;
	logic [MW-1:0]    mov_q;
	logic [YW-1:0]    head_start_q;
	logic [cscan_pkg::CC_W-1:0] cyl_count_q;

	logic             strobe_q;
	logic [YW-1:0]    visit_q;
	logic [MW-1:0]    total_q;
	logic             is_req_q;
	logic             ovf_q;
	logic             last_q;

	cscan_pkg::ram_req_t ram_req;
	logic [YW-1:0]    rdata;
	logic [YW-1:0]    top;
	logic [YW-1:0]    head;
	logic [YW-1:0]    key_sat;
	logic [YW-1:0]    add_a;
	logic [YW-1:0]    add_b;
	logic [MW-1:0]    mov_next;
	logic [CW-1:0]    i_inc;
	logic             key_done;

	cscan_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (rdata)
	);

	// disk geometry from the registers
	always_comb begin
		if (cyl_count_q == '0) begin
			top = '0;
		end else if (cyl_count_q > cscan_pkg::CC_W'(65536)) begin
			top = '1;
		end else begin
			top = YW'(cyl_count_q - cscan_pkg::CC_W'(1));
		end
		head = (head_start_q > top) ? top : head_start_q;
		key_sat = (rdata > top) ? top : rdata;
	end

	// one movement adder shared by the request, top and zero points of the sweep
	always_comb begin
		case (state_q)
			S_TOP: begin
				add_a = top;
				add_b = pos_q;
			end
			S_ZERO: begin
				add_a = top;
				add_b = '0;
			end
			default: begin
				add_a = rdata;
				add_b = pos_q;
			end
		endcase
		mov_next = mov_q + MW'(add_a - add_b);
	end

	assign i_inc = i_q + CW'(1);
	assign key_done = (i_inc == count_q);

	// store access per state
	always_comb begin
		ram_req = '0;
		case (state_q)
			S_IDLE: begin
				ram_req.we = start && (count_q < CW'(cscan_pkg::MAX_REQ));
				ram_req.waddr = count_q[AW-1:0];
				ram_req.wdata = request_cylinder;
			end
			S_KRD, S_ARD, S_BRD: begin
				ram_req.raddr = i_q[AW-1:0];
			end
			S_KEY: begin
				if (i_q == '0) begin
					ram_req.we = 1'b1;
					ram_req.waddr = '0;
					ram_req.wdata = key_sat;
				end else begin
					ram_req.raddr = AW'(i_q - CW'(1));
				end
			end
			S_CMP: begin
				ram_req.we = 1'b1;
				ram_req.waddr = j_q;
				if (rdata > key_q) begin
					ram_req.wdata = rdata;
					ram_req.raddr = j_q - AW'(2);
				end else begin
					ram_req.wdata = key_q;
				end
			end
			S_PUT: begin
				ram_req.we = 1'b1;
				ram_req.waddr = j_q;
				ram_req.wdata = key_q;
			end
			default: begin
				ram_req = '0;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_start_q <= '0;
			cyl_count_q <= cscan_pkg::CC_W'(200);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cscan_pkg::CFG_HEAD_START: head_start_q <= cfg_data[YW-1:0];
				cscan_pkg::CFG_CYL_COUNT: cyl_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and registered result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			dropped_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			cnt_b_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (count_q < CW'(cscan_pkg::MAX_REQ)) begin
							count_q <= count_q + CW'(1);
						end else begin
							dropped_q <= 1'b1;
						end
						if (last_request) begin
							i_q <= '0;
							state_q <= S_KRD;
						end
					end
				end
				S_KRD: begin
					state_q <= S_KEY;
				end
				S_KEY: begin
					key_q <= key_sat;
					if (i_q == '0) begin
						i_q <= i_inc;
						state_q <= key_done ? S_START : S_KRD;
					end else begin
						j_q <= i_q[AW-1:0];
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (rdata > key_q) begin
						j_q <= j_q - AW'(1);
						if (j_q == AW'(1)) begin
							state_q <= S_PUT;
						end
					end else begin
						i_q <= i_inc;
						state_q <= key_done ? S_START : S_KRD;
					end
				end
				S_PUT: begin
					i_q <= i_inc;
					state_q <= key_done ? S_START : S_KRD;
				end
				S_START: begin
					strobe_q <= 1'b1;
					visit_q <= head;
					total_q <= '0;
					is_req_q <= 1'b0;
					ovf_q <= dropped_q;
					last_q <= 1'b0;
					pos_q <= head;
					mov_q <= '0;
					cnt_b_q <= '0;
					i_q <= '0;
					state_q <= S_ARD;
				end
				S_ARD, S_BRD: begin
					state_q <= (state_q == S_ARD) ? S_AEV : S_BEV;
				end
				S_AEV: begin
					if (rdata > head) begin
						strobe_q <= 1'b1;
						visit_q <= rdata;
						total_q <= mov_next;
						is_req_q <= 1'b1;
						ovf_q <= dropped_q;
						last_q <= 1'b0;
						pos_q <= rdata;
						mov_q <= mov_next;
					end else begin
						cnt_b_q <= cnt_b_q + CW'(1);
					end
					i_q <= i_inc;
					state_q <= key_done ? S_TOP : S_ARD;
				end
				S_TOP: begin
					strobe_q <= 1'b1;
					visit_q <= top;
					total_q <= mov_next;
					is_req_q <= 1'b0;
					ovf_q <= dropped_q;
					last_q <= 1'b0;
					pos_q <= top;
					mov_q <= mov_next;
					state_q <= S_ZERO;
				end
				S_ZERO: begin
					strobe_q <= 1'b1;
					visit_q <= '0;
					total_q <= mov_next;
					is_req_q <= 1'b0;
					ovf_q <= dropped_q;
					last_q <= (cnt_b_q == '0);
					pos_q <= '0;
					mov_q <= mov_next;
					i_q <= '0;
					if (cnt_b_q == '0) begin
						count_q <= '0;
						dropped_q <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_BRD;
					end
				end
				S_BEV: begin
					strobe_q <= 1'b1;
					visit_q <= rdata;
					total_q <= mov_next;
					is_req_q <= 1'b1;
					ovf_q <= dropped_q;
					last_q <= (i_inc == cnt_b_q);
					pos_q <= rdata;
					mov_q <= mov_next;
					i_q <= i_inc;
					if (i_inc == cnt_b_q) begin
						count_q <= '0;
						dropped_q <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_BRD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign cfg_ready = !busy;
	assign strobe = strobe_q;
	assign visit_cylinder = visit_q;
	assign total_movement = total_q;
	assign is_request = is_req_q;
	assign overflow = ovf_q;
	assign last_visit = last_q;

endmodule

>>> rtl/cscan_checker.sv
// port-level checks of the c-scan disk scheduler and their binding
module cscan_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic last_request,
	input logic strobe,
	input logic overflow,
	input logic last_visit
);

	// a result that is not the final one comes while the sweep is running
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_visit |-> busy)
		else $error("non-final result seen while idle");

	// the final result is not directly followed by another result
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_visit |=> !strobe)
		else $error("result right after final result");

	// a request that is not the last only loads the store
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !last_request |=> !busy && !strobe)
		else $error("non-final request started a sweep");

	// the overflow flag holds through one sequence
	a_ovf_hold: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_visit |=> $stable(overflow))
		else $error("overflow changed inside a sequence");

endmodule

bind cscan_disk_scheduler_top cscan_checker u_cscan_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.last_request (last_request),
	.strobe       (strobe),
	.overflow     (overflow),
	.last_visit   (last_visit)
);

>>> tb/sv/cscan_disk_scheduler_top_tb.sv
// self-checking testbench of the c-scan disk scheduler: queued requests, sweep prediction
module cscan_disk_scheduler_top_tb;

	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES = 50;
	localparam int TIMEOUT_UNITS = 4000000;
	localparam int PHASE_ITEMS = 88;

	typedef enum logic [1:0] {OP_REQUEST, OP_CONFIG, OP_SETTLE} op_kind_t;

	// one pending word for the driver
	typedef struct packed {
		op_kind_t                          kind;
		logic [cscan_pkg::CYL_W-1:0]       cyl;
		logic                              last;
		logic [cscan_pkg::CFG_IDX_W-1:0]   idx;
		logic [cscan_pkg::CC_W-1:0]        data;
		int                                idle_pct;
	} pending_op_t;

	// one visited point of the sweep
	typedef struct packed {
		logic [cscan_pkg::CYL_W-1:0] cyl;
		logic [cscan_pkg::MOV_W-1:0] movement;
		logic                        serviced;
		logic                        dropped;
		logic                        final_visit;
	} visit_t;

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [cscan_pkg::CYL_W-1:0] request_cylinder = '0;
	logic last_request = 1'b0;
	logic strobe;
	logic [cscan_pkg::CYL_W-1:0] visit_cylinder;
	logic [cscan_pkg::MOV_W-1:0] total_movement;
	logic is_request;
	logic overflow;
	logic last_visit;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [cscan_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [cscan_pkg::CC_W-1:0] cfg_data = '0;

	pending_op_t pending_ops[$];
	visit_t expected_visits[$];
	int error_count = 0;
	logic settle_wait = 1'b0;
	int settle_left = 0;

	// predictor state: held batch and register copies
	logic [cscan_pkg::CYL_W-1:0] held_requests[cscan_pkg::MAX_REQ];
	int unsigned held_count = 0;
	logic requests_dropped = 1'b0;
	logic [cscan_pkg::CYL_W-1:0] model_head_start = '0;
	logic [cscan_pkg::CC_W-1:0] model_cyl_count = 17'd200;

	// register values the generator has scheduled
	logic [cscan_pkg::CYL_W-1:0] gen_head = '0;
	logic [cscan_pkg::CC_W-1:0] gen_cc = 17'd200;

	cscan_disk_scheduler_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request_cylinder(request_cylinder),
		.last_request(last_request),
		.strobe(strobe),
		.visit_cylinder(visit_cylinder),
		.total_movement(total_movement),
		.is_request(is_request),
		.overflow(overflow),
		.last_visit(last_visit),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// top cylinder after clamping a zero or oversized count
	function automatic int unsigned disk_top(input logic [cscan_pkg::CC_W-1:0] count);
		int unsigned eff;
		eff = 32'(count);
		if (eff == 0) eff = 1;
		if (eff > 65536) eff = 65536;
		return eff - 1;
	endfunction

	function automatic visit_t make_visit(input int unsigned cyl, input int unsigned mov,
			input logic serviced);
		visit_t v;
		v.cyl = cyl[cscan_pkg::CYL_W-1:0];
		v.movement = mov[cscan_pkg::MOV_W-1:0];
		v.serviced = serviced;
		v.dropped = requests_dropped;
		v.final_visit = 1'b0;
		return v;
	endfunction

	// store one request; on the last one plan the whole sweep
	function automatic void predict_sweep(input logic [cscan_pkg::CYL_W-1:0] cyl,
			input logic last);
		int unsigned sorted_cyl[cscan_pkg::MAX_REQ];
		int unsigned top, head, pos, mov, v;
		int j;
		visit_t sweep[$];
		if (held_count < cscan_pkg::MAX_REQ) begin
			held_requests[held_count] = cyl;
			held_count++;
		end else begin
			requests_dropped = 1'b1;
		end
		if (!last) return;
		top = disk_top(model_cyl_count);
		head = (32'(model_head_start) > top) ? top : 32'(model_head_start);
		// saturate and sort ascending
		for (int i = 0; i < held_count; i++) begin
			v = 32'(held_requests[i]);
			if (v > top) v = top;
			j = i;
			while (j > 0 && sorted_cyl[j-1] > v) begin
				sorted_cyl[j] = sorted_cyl[j-1];
				j--;
			end
			sorted_cyl[j] = v;
		end
		// upward sweep from the head
		pos = head;
		mov = 0;
		sweep.push_back(make_visit(head, mov, 1'b0));
		for (int i = 0; i < held_count; i++) begin
			if (sorted_cyl[i] > head) begin
				mov += sorted_cyl[i] - pos;
				pos = sorted_cyl[i];
				sweep.push_back(make_visit(pos, mov, 1'b1));
			end
		end
		mov += top - pos;
		sweep.push_back(make_visit(top, mov, 1'b0));
		// return to zero, then the low side
		mov += top;
		pos = 0;
		sweep.push_back(make_visit(0, mov, 1'b0));
		for (int i = 0; i < held_count; i++) begin
			if (sorted_cyl[i] <= head) begin
				mov += sorted_cyl[i] - pos;
				pos = sorted_cyl[i];
				sweep.push_back(make_visit(pos, mov, 1'b1));
			end
		end
		sweep[sweep.size()-1].final_visit = 1'b1;
		foreach (sweep[i]) expected_visits.push_back(sweep[i]);
		held_count = 0;
		requests_dropped = 1'b0;
	endfunction

	function automatic void compare_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, actual %0d", field, want, got);
			error_count++;
		end
	endfunction

	// stimulus queue helpers
	function automatic void queue_request(input logic [cscan_pkg::CYL_W-1:0] cyl,
			input logic last, input int pct);
		pending_op_t op;
		op = '0;
		op.kind = OP_REQUEST;
		op.cyl = cyl;
		op.last = last;
		op.idle_pct = pct;
		pending_ops.push_back(op);
	endfunction

	function automatic void queue_config(input logic [cscan_pkg::CFG_IDX_W-1:0] idx,
			input logic [cscan_pkg::CC_W-1:0] data, input int pct);
		pending_op_t op;
		op = '0;
		op.kind = OP_CONFIG;
		op.idx = idx;
		op.data = data;
		op.idle_pct = pct;
		pending_ops.push_back(op);
		if (idx == cscan_pkg::CFG_HEAD_START) gen_head = data[cscan_pkg::CYL_W-1:0];
		else gen_cc = data;
	endfunction

	function automatic void queue_settle(input int pct);
		pending_op_t op;
		op = '0;
		op.kind = OP_SETTLE;
		op.idle_pct = pct;
		pending_ops.push_back(op);
	endfunction

	// new cylinder count first, head chosen against its top
	function automatic void queue_random_config(input int pct);
		int unsigned r, top;
		logic [cscan_pkg::CC_W-1:0] count;
		logic [cscan_pkg::CYL_W-1:0] head;
		r = $urandom_range(99);
		if (r < 40) count = cscan_pkg::CC_W'($urandom_range(400, 1));
		else if (r < 60) count = cscan_pkg::CC_W'($urandom_range(65536, 1));
		else if (r < 68) count = 17'd65536;
		else if (r < 74) count = 17'd1;
		else if (r < 79) count = 17'd0;
		else if (r < 86) count = cscan_pkg::CC_W'($urandom_range(131071, 65537));
		else count = 17'd200;
		top = disk_top(count);
		r = $urandom_range(99);
		if (r < 60) head = cscan_pkg::CYL_W'($urandom_range(top, 0));
		else if (r < 75) head = top[cscan_pkg::CYL_W-1:0];
		else if (r < 82) head = '0;
		else head = cscan_pkg::CYL_W'($urandom);
		queue_config(cscan_pkg::CFG_CYL_COUNT, count, pct);
		queue_config(cscan_pkg::CFG_HEAD_START, {1'($urandom_range(1)), head}, pct);
	endfunction

	// one batch, mostly on the disk, some beyond it, duplicates and edges
	function automatic void queue_batch(input int unsigned len, input int pct);
		int unsigned top, head, r;
		logic [cscan_pkg::CYL_W-1:0] cyl, prev_cyl;
		top = disk_top(gen_cc);
		head = (32'(gen_head) > top) ? top : 32'(gen_head);
		prev_cyl = '0;
		for (int unsigned i = 0; i < len; i++) begin
			r = $urandom_range(99);
			if (r < 55) cyl = cscan_pkg::CYL_W'($urandom_range(top, 0));
			else if (r < 65) cyl = cscan_pkg::CYL_W'($urandom_range(65535, top));
			else if (r < 75) cyl = cscan_pkg::CYL_W'($urandom);
			else if (r < 82) cyl = head[cscan_pkg::CYL_W-1:0];
			else if (r < 88) cyl = top[cscan_pkg::CYL_W-1:0];
			else if (r < 93) cyl = prev_cyl;
			else if (r < 97) cyl = '0;
			else cyl = 16'hFFFF;
			queue_request(cyl, i == len - 1, pct);
			prev_cyl = cyl;
		end
	endfunction

	// driver: one word at a time, hold until the handshake, random gaps
	always @(posedge clk) begin : driver
		pending_op_t op;
		logic start_next, cfg_next;
		start_next = start;
		cfg_next = cfg_valid;
		if (arst_n) begin
			if (start && !busy) start_next = 1'b0;
			if (cfg_valid && cfg_ready) cfg_next = 1'b0;
			if (!start_next && !cfg_next) begin
				if (settle_wait) begin
					if (!start && !busy && expected_visits.size() == 0) begin
						settle_wait = 1'b0;
						settle_left = SETTLE_CYCLES;
					end
				end else if (settle_left != 0) begin
					settle_left--;
				end else if (pending_ops.size() != 0 &&
						$urandom_range(99) >= pending_ops[0].idle_pct) begin
					op = pending_ops.pop_front();
					case (op.kind)
					OP_REQUEST: begin
						start_next = 1'b1;
						request_cylinder <= op.cyl;
						last_request <= op.last;
					end
					OP_CONFIG: begin
						cfg_next = 1'b1;
						cfg_index <= op.idx;
						cfg_data <= op.data;
					end
					OP_SETTLE: begin
						settle_wait = 1'b1;
					end
					default: ;
					endcase
				end
			end
		end
		start <= start_next;
		cfg_valid <= cfg_next;
	end

	// monitor: check visits, then track accepted words
	always @(posedge clk) begin : monitor
		visit_t want;
		if (arst_n) begin
			if (strobe) begin
				if (expected_visits.size() == 0) begin
					$error("visit with no expectation: cylinder %0d", visit_cylinder);
					error_count++;
				end else begin
					want = expected_visits.pop_front();
					compare_field("visit_cylinder", 32'(want.cyl), 32'(visit_cylinder));
					compare_field("total_movement", 32'(want.movement),
						32'(total_movement));
					compare_field("is_request", 32'(want.serviced), 32'(is_request));
					compare_field("overflow", 32'(want.dropped), 32'(overflow));
					compare_field("last_visit", 32'(want.final_visit), 32'(last_visit));
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == cscan_pkg::CFG_HEAD_START)
					model_head_start = cfg_data[cscan_pkg::CYL_W-1:0];
				else
					model_cyl_count = cfg_data;
			end
			if (start && !busy) predict_sweep(request_cylinder, last_request);
		end
	end

	// stimulus, reset and end of run
	initial begin : stimulus
		int phase_items;
		int unsigned len, r;
		int pct;
		logic first;
		// single request at the reset head
		queue_request(16'd0, 1'b1, 23);
		// duplicates, request at top, at head, beyond the disk
		queue_settle(23);
		queue_config(cscan_pkg::CFG_HEAD_START, 17'd100, 23);
		queue_config(cscan_pkg::CFG_CYL_COUNT, 17'd200, 23);
		queue_request(16'd150, 1'b0, 23);
		queue_request(16'd50, 1'b0, 23);
		queue_request(16'd199, 1'b0, 23);
		queue_request(16'd199, 1'b0, 23);
		queue_request(16'd100, 1'b0, 23);
		queue_request(16'd250, 1'b0, 23);
		queue_request(16'hFFFF, 1'b1, 23);
		// zero count taken as one, head beyond the disk
		queue_settle(23);
		queue_config(cscan_pkg::CFG_HEAD_START, 17'h0FFFF, 23);
		queue_config(cscan_pkg::CFG_CYL_COUNT, 17'd0, 23);
		queue_request(16'd0, 1'b0, 23);
		queue_request(16'd5, 1'b1, 23);
		// count above the largest disk
		queue_settle(23);
		queue_config(cscan_pkg::CFG_HEAD_START, 17'd0, 23);
		queue_config(cscan_pkg::CFG_CYL_COUNT, 17'h1FFFF, 23);
		queue_request(16'hFFFF, 1'b0, 23);
		queue_request(16'd0, 1'b0, 23);
		queue_request(16'h8000, 1'b1, 23);
		// largest disk, head data with the upper bit set
		queue_settle(23);
		queue_config(cscan_pkg::CFG_HEAD_START, 17'h1FFFF, 23);
		queue_config(cscan_pkg::CFG_CYL_COUNT, 17'd65536, 23);
		queue_request(16'hFFFF, 1'b0, 23);
		queue_request(16'd1, 1'b1, 23);
		// one-cylinder disk
		queue_settle(23);
		queue_config(cscan_pkg::CFG_HEAD_START, 17'd0, 23);
		queue_config(cscan_pkg::CFG_CYL_COUNT, 17'd1, 23);
		queue_request(16'd0, 1'b0, 23);
		queue_request(16'hFFFF, 1'b1, 23);

		// random phases: sender idles often, very often, never
		for (int p = 0; p < 3; p++) begin
			pct = (p == 0) ? 23 : (p == 1) ? 63 : 0;
			queue_settle(pct);
			queue_random_config(pct);
			phase_items = 0;
			first = 1'b1;
			while (phase_items < PHASE_ITEMS) begin
				if (!first && $urandom_range(99) < 20) begin
					queue_settle(pct);
					if ($urandom_range(3) != 0) queue_random_config(pct);
				end
				r = $urandom_range(99);
				if (first && p == 0) len = 36;
				else if (first && p == 2) len = cscan_pkg::MAX_REQ + 1;
				else if (r < 80) len = $urandom_range(8, 1);
				else if (r < 95) len = $urandom_range(20, 9);
				else len = $urandom_range(36, 30);
				queue_batch(len, pct);
				phase_items += int'(len);
				first = 1'b0;
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// wait for the last word and its visits
		@(negedge clk);
		while (pending_ops.size() != 0 || start || cfg_valid || settle_wait ||
				settle_left != 0 || expected_visits.size() != 0 || busy)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_visits.size() != 0) begin
			$error("%0d visits never arrived", expected_visits.size());
			error_count++;
		end
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// watchdog
	initial begin : watchdog
		#(TIMEOUT_UNITS);
		$display("Verification failed");
		$finish;
	end

endmodule
